// ===== rtl/mi3_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mi3_pkg
// Shared types and constants for the 3x3 matrix inverse pipeline.
// ---------------------------------------------------------------------------
package mi3_pkg;

   localparam int ENTRY_W  = 16;
   localparam int RES_W    = 32;
   localparam int PROD_W   = 2 * ENTRY_W;
   localparam int ADJ_W    = PROD_W + 1;
   localparam int TERM_W   = ENTRY_W + ADJ_W;
   localparam int DET_W    = TERM_W + 2;
   localparam int THR_W    = 48;
   localparam int SHIFT    = 24;
   localparam int NUM_W    = ADJ_W + SHIFT;
   localparam int CMP_W    = DET_W + RES_W;
   localparam int LANES    = 9;
   localparam int DIV_LAT  = RES_W + 2;
   localparam int FRONT_LAT = 5;

   localparam logic [RES_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
   localparam logic [RES_W-1:0] NEG_LIMIT = 32'h8000_0000;

   typedef struct packed {
      logic signed [ENTRY_W-1:0] a00;
      logic signed [ENTRY_W-1:0] a01;
      logic signed [ENTRY_W-1:0] a02;
      logic signed [ENTRY_W-1:0] a10;
      logic signed [ENTRY_W-1:0] a11;
      logic signed [ENTRY_W-1:0] a12;
      logic signed [ENTRY_W-1:0] a20;
      logic signed [ENTRY_W-1:0] a21;
      logic signed [ENTRY_W-1:0] a22;
   } req_type;

   typedef struct packed {
      logic signed [RES_W-1:0] b00;
      logic signed [RES_W-1:0] b01;
      logic signed [RES_W-1:0] b02;
      logic signed [RES_W-1:0] b10;
      logic signed [RES_W-1:0] b11;
      logic signed [RES_W-1:0] b12;
      logic signed [RES_W-1:0] b20;
      logic signed [RES_W-1:0] b21;
      logic signed [RES_W-1:0] b22;
      logic                    singular;
      logic                    clipped;
   } rsp_type;

   typedef struct packed {
      logic                        valid;
      logic                        singular;
      logic [DET_W-1:0]            dmag;
      logic                        dneg;
      logic [LANES-1:0][ADJ_W-1:0] cmag;
      logic [LANES-1:0]            cneg;
   } cof_type;

endpackage

// ===== rtl/matrix3x3_inverse_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// matrix3x3_inverse_top
// 3x3 matrix inverse by the adjugate with nine parallel divider lanes.
// ---------------------------------------------------------------------------
// Path: the mi3_cof front end, the divider lanes, then the merge register.
// Throughput: one matrix per cycle; busy is low except during reset.
// The 32-stage restoring divider in each lane sets the latency.
// Reset clears the pipeline valid bits and sets the threshold register thr_ff to 1.
// Results are strobed for one cycle; the receiver cannot stall.
module matrix3x3_inverse_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mi3_pkg::req_type req_data,
   output logic             rsp_valid,
   output mi3_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [3:0]       paddr,
   input  logic [63:0]      pwdata,
   output logic [63:0]      prdata,
   output logic             pready
);

   logic [mi3_pkg::THR_W-1:0] thr_ff;
   mi3_pkg::cof_type          cof_w;
   logic [mi3_pkg::LANES-1:0][mi3_pkg::RES_W-1:0] res_w;
   logic [mi3_pkg::LANES-1:0] clip_w;

   assign busy   = reset;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= mi3_pkg::THR_W'(1);
      end else if (psel && penable && pwrite && !paddr[3]) begin
         thr_ff <= pwdata[mi3_pkg::THR_W-1:0];
      end
   end

   assign prdata = paddr[3] ? 64'd0 : {{(64-mi3_pkg::THR_W){1'b0}}, thr_ff};

   mi3_cof u_cof (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .in_data  (req_data),
      .thr      (thr_ff),
      .cof      (cof_w)
   );

   for (genvar g = 0; g < mi3_pkg::LANES; g++) begin : g_lane
      mi3_div_lane u_lane (
         .clock (clock),
         .cmag  (cof_w.cmag[g]),
         .cneg  (cof_w.cneg[g]),
         .dmag  (cof_w.dmag),
         .dneg  (cof_w.dneg),
         .res   (res_w[g]),
         .clip  (clip_w[g])
      );
   end

   mi3_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (cof_w.valid),
      .in_singular (cof_w.singular),
      .res         (res_w),
      .clip        (clip_w),
      .out_valid   (rsp_valid),
      .out_data    (rsp_data)
   );

endmodule

// ===== rtl/mi3_cof.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mi3_cof
// Cofactor, determinant and singular test front end, five stages.
// ---------------------------------------------------------------------------
module mi3_cof (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  mi3_pkg::req_type          in_data,
   input  logic [mi3_pkg::THR_W-1:0] thr,
   output mi3_pkg::cof_type          cof
);

   localparam logic [3:0] MI [9][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
   };

   logic signed [mi3_pkg::ENTRY_W-1:0] a_w [9];
   logic [mi3_pkg::FRONT_LAT-2:0]      vld_ff;

   logic signed [mi3_pkg::PROD_W-1:0]  pl_ff [9];
   logic signed [mi3_pkg::PROD_W-1:0]  pr_ff [9];
   logic signed [mi3_pkg::ENTRY_W-1:0] r1_ff [3];
   logic signed [mi3_pkg::ENTRY_W-1:0] r2_ff [3];
   logic signed [mi3_pkg::ADJ_W-1:0]   adj2_ff [9];
   logic signed [mi3_pkg::ADJ_W-1:0]   adj3_ff [9];
   logic signed [mi3_pkg::ADJ_W-1:0]   adj4_ff [9];
   logic signed [mi3_pkg::TERM_W-1:0]  t_ff [3];
   logic signed [mi3_pkg::DET_W-1:0]   det_ff;
   mi3_pkg::cof_type                   cof_ff;

   assign a_w[0] = in_data.a00;
   assign a_w[1] = in_data.a01;
   assign a_w[2] = in_data.a02;
   assign a_w[3] = in_data.a10;
   assign a_w[4] = in_data.a11;
   assign a_w[5] = in_data.a12;
   assign a_w[6] = in_data.a20;
   assign a_w[7] = in_data.a21;
   assign a_w[8] = in_data.a22;

   always_ff @(posedge clock) begin
      for (int k = 0; k < 9; k++) begin
         pl_ff[k]   <= a_w[MI[k][0]] * a_w[MI[k][1]];
         pr_ff[k]   <= a_w[MI[k][2]] * a_w[MI[k][3]];
         adj2_ff[k] <= $signed({pl_ff[k][mi3_pkg::PROD_W-1], pl_ff[k]})
                       - $signed({pr_ff[k][mi3_pkg::PROD_W-1], pr_ff[k]});
         adj3_ff[k] <= adj2_ff[k];
         adj4_ff[k] <= adj3_ff[k];
         cof_ff.cneg[k] <= adj4_ff[k][mi3_pkg::ADJ_W-1];
         cof_ff.cmag[k] <= adj4_ff[k][mi3_pkg::ADJ_W-1] ? -adj4_ff[k] : adj4_ff[k];
      end
      for (int j = 0; j < 3; j++) begin
         r1_ff[j] <= a_w[j];
         r2_ff[j] <= r1_ff[j];
      end
      t_ff[0] <= r2_ff[0] * adj2_ff[0];
      t_ff[1] <= r2_ff[1] * adj2_ff[3];
      t_ff[2] <= r2_ff[2] * adj2_ff[6];
      det_ff  <= mi3_pkg::DET_W'(t_ff[0]) + mi3_pkg::DET_W'(t_ff[1])
                 + mi3_pkg::DET_W'(t_ff[2]);
      cof_ff.dneg     <= det_ff[mi3_pkg::DET_W-1];
      cof_ff.dmag     <= det_ff[mi3_pkg::DET_W-1] ? -det_ff : det_ff;
      cof_ff.singular <= (det_ff == '0) ||
                         ((det_ff[mi3_pkg::DET_W-1] ? -det_ff : det_ff)
                          < {{(mi3_pkg::DET_W-mi3_pkg::THR_W){1'b0}}, thr});
      if (reset) begin
         vld_ff       <= '0;
         cof_ff.valid <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[mi3_pkg::FRONT_LAT-3:0], in_valid};
         cof_ff.valid <= vld_ff[mi3_pkg::FRONT_LAT-2];
      end
   end

   assign cof = cof_ff;

endmodule

// ===== rtl/mi3_div_lane.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mi3_div_lane
// One divider lane: restoring division, one quotient bit per stage, saturate.
// ---------------------------------------------------------------------------
module mi3_div_lane (
   input  logic                          clock,
   input  logic [mi3_pkg::ADJ_W-1:0]     cmag,
   input  logic                          cneg,
   input  logic [mi3_pkg::DET_W-1:0]     dmag,
   input  logic                          dneg,
   output logic [mi3_pkg::RES_W-1:0]     res,
   output logic                          clip
);

   localparam int NS = mi3_pkg::RES_W;

   logic [mi3_pkg::NUM_W-1:0] num_w;
   logic [mi3_pkg::NUM_W-1:0] rem_ff [NS+1];
   logic [mi3_pkg::DET_W-1:0] d_ff   [NS+1];
   logic [NS-1:0]             q_ff   [NS+1];
   logic                      ovf_ff [NS+1];
   logic                      neg_ff [NS+1];
   logic [mi3_pkg::CMP_W-1:0] trial_w [NS];
   logic                      fit_w   [NS];
   logic [NS-1:0]             res_ff;
   logic                      clip_ff;
   logic                      sat_w;

   assign num_w = {cmag, {mi3_pkg::SHIFT{1'b0}}};

   always_comb begin
      for (int k = 0; k < NS; k++) begin
         trial_w[k] = {{NS{1'b0}}, d_ff[k]} << (NS - 1 - k);
         fit_w[k]   = {{(mi3_pkg::CMP_W-mi3_pkg::NUM_W){1'b0}}, rem_ff[k]} >= trial_w[k];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= num_w;
      d_ff[0]   <= dmag;
      q_ff[0]   <= '0;
      neg_ff[0] <= cneg ^ dneg;
      ovf_ff[0] <= {{(mi3_pkg::CMP_W-mi3_pkg::NUM_W){1'b0}}, num_w} >= {dmag, {NS{1'b0}}};
      for (int k = 0; k < NS; k++) begin
         d_ff[k+1]   <= d_ff[k];
         neg_ff[k+1] <= neg_ff[k];
         ovf_ff[k+1] <= ovf_ff[k];
         if (fit_w[k]) begin
            rem_ff[k+1] <= rem_ff[k] - trial_w[k][mi3_pkg::NUM_W-1:0];
            q_ff[k+1]   <= q_ff[k] | (NS'(1) << (NS - 1 - k));
         end else begin
            rem_ff[k+1] <= rem_ff[k];
            q_ff[k+1]   <= q_ff[k];
         end
      end
   end

   always_comb begin
      if (neg_ff[NS]) begin
         sat_w = ovf_ff[NS] || (q_ff[NS] > mi3_pkg::NEG_LIMIT);
      end else begin
         sat_w = ovf_ff[NS] || q_ff[NS][NS-1];
      end
   end

   always_ff @(posedge clock) begin
      clip_ff <= sat_w;
      if (neg_ff[NS]) begin
         res_ff <= sat_w ? mi3_pkg::NEG_LIMIT : -q_ff[NS];
      end else begin
         res_ff <= sat_w ? mi3_pkg::POS_LIMIT : q_ff[NS];
      end
   end

   assign res  = res_ff;
   assign clip = clip_ff;

endmodule

// ===== rtl/mi3_merge.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mi3_merge
// Aligns control with the lanes, merges clip flags and forms the result beat.
// ---------------------------------------------------------------------------
module mi3_merge (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   input  logic                                        in_singular,
   input  logic [mi3_pkg::LANES-1:0][mi3_pkg::RES_W-1:0] res,
   input  logic [mi3_pkg::LANES-1:0]                   clip,
   output logic                                        out_valid,
   output mi3_pkg::rsp_type                            out_data
);

   localparam int LAST = mi3_pkg::DIV_LAT - 1;

   logic [mi3_pkg::DIV_LAT-1:0] vld_ff;
   logic [mi3_pkg::DIV_LAT-1:0] sing_ff;
   logic                        valid_ff;
   mi3_pkg::rsp_type            rsp_ff;
   logic [mi3_pkg::LANES-1:0][mi3_pkg::RES_W-1:0] val_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         vld_ff   <= {vld_ff[LAST-1:0], in_valid};
         valid_ff <= vld_ff[LAST];
      end
   end

   always_comb begin
      for (int k = 0; k < mi3_pkg::LANES; k++) begin
         val_w[k] = sing_ff[LAST] ? '0 : res[k];
      end
   end

   always_ff @(posedge clock) begin
      sing_ff         <= {sing_ff[LAST-1:0], in_singular};
      rsp_ff.b00      <= val_w[0];
      rsp_ff.b01      <= val_w[1];
      rsp_ff.b02      <= val_w[2];
      rsp_ff.b10      <= val_w[3];
      rsp_ff.b11      <= val_w[4];
      rsp_ff.b12      <= val_w[5];
      rsp_ff.b20      <= val_w[6];
      rsp_ff.b21      <= val_w[7];
      rsp_ff.b22      <= val_w[8];
      rsp_ff.singular <= sing_ff[LAST];
      rsp_ff.clipped  <= !sing_ff[LAST] && (|clip);
   end

   assign out_valid = valid_ff;
   assign out_data  = rsp_ff;

   a_sing_noclip: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_ff.singular |-> !rsp_ff.clipped)
      else $error("singular beat with clip set");
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_ff.singular |-> rsp_ff.b00 == 0 && rsp_ff.b11 == 0 && rsp_ff.b22 == 0)
      else $error("singular beat with nonzero entries");
   a_valid_out: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAST] |=> valid_ff)
      else $error("aligned beat lost at output");

endmodule
